### sv/byte_permission_guest_memory_unit_assert.svh
// Assertion macros shared by the guest memory unit RTL.
`ifndef BYTE_PERMISSION_GUEST_MEMORY_UNIT_ASSERT_SVH
`define BYTE_PERMISSION_GUEST_MEMORY_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BPGM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpgm assertion failed");
`define BPGM_NEVER(lbl, clk, rst_n, expr) \
    `BPGM_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define BPGM_ASSERT(lbl, clk, rst_n, prop)
`define BPGM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### sv/bpgm_pkg.sv
// Shared types and constants of the guest memory unit.
package bpgm_pkg;
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_PERM  = 2'd2,
        OP_ALLOC = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_READ_FAULT  = 3'd1,
        ST_WRITE_FAULT = 3'd2,
        ST_DENIED      = 3'd3,
        ST_BAD_LENGTH  = 3'd4,
        ST_OOM         = 3'd5
    } t_status;

    localparam logic [3:0]  PERM_READ  = 4'h1;
    localparam logic [3:0]  PERM_WRITE = 4'h2;
    localparam logic [3:0]  PERM_EXEC  = 4'h4;
    localparam logic [3:0]  PERM_RAW   = 4'h8;
    localparam logic [3:0]  PERM_RESET = 4'hA;
    localparam logic [33:0] ALLOC_ROUND = 34'h0000_000F;
    localparam logic [33:0] ALLOC_MASK  = 34'h0_FFFF_FFF0;
    localparam int          LANES = 8;
endpackage

### sv/bpgm_ram.sv
// Generic single-port RAM with registered read.
module bpgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read data registered; a read during a write returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### sv/byte_permission_guest_memory_unit.sv
// Top level: byte-granular permission guest memory unit.
// After reset a clearing pass over all MEM_BYTES locations runs with busy high.
// Flow: decode; reads and writes scan their bytes, are evaluated, and writes then run a
// write pass (one RAM port); set_perm/allocate run a fill pass; rejects respond.
// Next request is accepted in the cycle after o_done; o_done lasts one cycle, no stall.
// Reset is synchronous, active low; clears control and base/pointer registers.
`include "byte_permission_guest_memory_unit_assert.svh"
module byte_permission_guest_memory_unit #(
    parameter int MEM_BYTES        = 65536,
    parameter int PAGE_BYTES       = 4096,
    parameter int MAX_ACCESS_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_address,
    input  logic [16:0] i_length,
    input  logic [63:0] i_write_data,
    input  logic [3:0]  i_perm_bits,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_done,
    output logic [63:0] o_read_data,
    output logic [2:0]  o_status,
    output logic [3:0]  o_byte_count,
    output logic [31:0] o_alloc_address
);
    import bpgm_pkg::*;

    localparam int AW     = $clog2(MEM_BYTES);
    localparam int PS     = $clog2(PAGE_BYTES);
    localparam int DIRTY  = (MEM_BYTES / PAGE_BYTES > 0) ? MEM_BYTES / PAGE_BYTES : 1;
    localparam int DPW    = ($clog2(DIRTY) > 0) ? $clog2(DIRTY) : 1;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DECODE   = 9'b000000100,
        S_SCAN     = 9'b000001000,
        S_SCAN_END = 9'b000010000,
        S_EVAL     = 9'b000100000,
        S_WRITE    = 9'b001000000,
        S_FILL     = 9'b010000000,
        S_RESP     = 9'b100000000
    } t_state;

    t_state      r_state;
    logic [AW-1:0] r_clr;
    logic [16:0] r_cnt;
    logic [1:0]  r_op;
    logic [31:0] r_addr;
    logic [16:0] r_len;
    logic [63:0] r_wdata;
    logic [3:0]  r_perm;
    logic [31:0] r_base;
    logic [31:0] r_next;
    logic [AW-1:0] r_off;
    logic        r_ok;
    logic [63:0] r_rdata;
    logic [2:0]  r_status;
    logic [3:0]  r_count;
    logic [31:0] r_alloc;
    logic [3:0]  r_saved [LANES];
    logic        r_rv;
    logic [2:0]  r_ri;
    logic [DIRTY-1:0] r_dirty;

    // window and allocation arithmetic
    logic [33:0] base34, top34, end34, al34, nend34;
    logic        in_win, len_bad, last;
    logic [AW-1:0] last_off;
    logic [DIRTY-1:0] dirty_set;
    always_comb begin
        base34 = {2'b00, r_base};
        top34  = base34 + 34'(MEM_BYTES);
        if (top34 > 34'h1_0000_0000) begin
            top34 = 34'h1_0000_0000;
        end
        end34    = {2'b00, r_addr} + {17'b0, r_len};
        in_win   = ({2'b00, r_addr} >= base34) && (end34 <= top34);
        len_bad  = (r_len == 17'd0) || (r_len > 17'(MAX_ACCESS_BYTES));
        al34     = ({17'b0, r_len} + ALLOC_ROUND) & ALLOC_MASK;
        nend34   = {2'b00, r_next} + al34;
        last     = (r_cnt == r_len - 17'd1);
        last_off = r_off + AW'(r_len) - AW'(1);
        // pages of the first and last written byte
        dirty_set = '0;
        dirty_set[DPW'((r_off >> PS) % DIRTY)]    = 1'b1;
        dirty_set[DPW'((last_off >> PS) % DIRTY)] = 1'b1;
    end

    // RAM port control
    logic [AW-1:0] ram_addr;
    logic          data_we, perm_we;
    logic [7:0]    data_wr, data_rd;
    logic [3:0]    perm_wr, perm_rd, perm_old;
    always_comb begin
        perm_old = r_saved[r_cnt[2:0]];
        ram_addr = (r_state == S_CLEAR) ? r_clr : r_off + AW'(r_cnt);
        data_we  = (r_state == S_CLEAR) || (r_state == S_WRITE);
        perm_we  = data_we || (r_state == S_FILL);
        data_wr  = (r_state == S_CLEAR) ? 8'h00 : r_wdata[{r_cnt[2:0], 3'b000} +: 8];
        case (r_state)
            S_CLEAR: perm_wr = PERM_RESET;
            S_FILL:  perm_wr = r_perm;
            default: perm_wr = ((perm_old & PERM_RAW) != 4'h0)
                             ? (PERM_READ | PERM_WRITE | (perm_old & PERM_EXEC))
                             : perm_old;
        endcase
    end

    bpgm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_data (
        .i_clk(i_clk), .i_we(data_we), .i_addr(ram_addr),
        .i_wdata(data_wr), .o_rdata(data_rd)
    );
    bpgm_ram #(.WIDTH(4), .DEPTH(MEM_BYTES)) u_perm (
        .i_clk(i_clk), .i_we(perm_we), .i_addr(ram_addr),
        .i_wdata(perm_wr), .o_rdata(perm_rd)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_rv    <= 1'b0;
            r_base  <= '0;
            r_next  <= '0;
            r_dirty <= '0;
        end else begin
            r_rv <= (r_state == S_SCAN);
            r_ri <= r_cnt[2:0];
            // scan data returns in the cycle after its address
            if (r_rv) begin
                r_saved[r_ri] <= perm_rd;
                r_rdata[{r_ri, 3'b000} +: 8] <= data_rd;
                if (r_op == OP_WRITE) begin
                    if ((perm_rd & (PERM_WRITE | PERM_RAW)) == 4'h0) r_ok <= 1'b0;
                end else if ((perm_rd & PERM_READ) == 4'h0) begin
                    r_ok <= 1'b0;
                end
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MEM_BYTES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_operation;
                        r_addr   <= i_address;
                        r_len    <= i_length;
                        r_wdata  <= i_write_data;
                        r_perm   <= i_perm_bits;
                        r_status <= ST_OK;
                        r_count  <= '0;
                        r_alloc  <= '0;
                        r_rdata  <= '0;
                        r_ok     <= 1'b1;
                        r_cnt    <= '0;
                        r_state  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (r_op)
                        OP_READ, OP_WRITE: begin
                            r_off <= AW'(r_addr - r_base);
                            if (len_bad) begin
                                r_status <= ST_BAD_LENGTH;
                                r_state  <= S_RESP;
                            end else if (!in_win) begin
                                r_status <= (r_op == OP_WRITE) ? ST_WRITE_FAULT
                                                               : ST_READ_FAULT;
                                r_state  <= S_RESP;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        OP_PERM: begin
                            r_off <= AW'(r_addr - r_base);
                            if (!in_win) begin
                                r_status <= ST_WRITE_FAULT;
                                r_state  <= S_RESP;
                            end else if (r_len != 17'd0) begin
                                r_state <= S_FILL;
                            end else begin
                                r_state <= S_RESP;
                            end
                        end
                        default: begin
                            r_off <= AW'(r_next - r_base);
                            if (r_next < r_base || nend34 >= top34) begin
                                r_status <= ST_OOM;
                                r_state  <= S_RESP;
                            end else begin
                                r_next  <= nend34[31:0];
                                r_alloc <= r_next;
                                r_state <= (r_len != 17'd0) ? S_FILL : S_RESP;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    if (last) begin
                        r_cnt   <= '0;
                        r_state <= S_SCAN_END;
                    end else begin
                        r_cnt <= r_cnt + 17'd1;
                    end
                end
                S_SCAN_END: r_state <= S_EVAL;
                S_EVAL: begin
                    if (!r_ok) begin
                        r_status <= ST_DENIED;
                        r_rdata  <= '0;
                        r_state  <= S_RESP;
                    end else begin
                        r_count <= r_len[3:0];
                        if (r_op == OP_WRITE) begin
                            r_rdata <= '0;
                            r_dirty <= r_dirty | dirty_set;
                            r_state <= S_WRITE;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_WRITE, S_FILL: begin
                    r_cnt <= r_cnt + 17'd1;
                    if (last) r_state <= S_RESP;
                end
                S_RESP:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            // base write also resets the bump pointer
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
                r_next <= i_cfg_wdata;
            end
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = (r_state == S_RESP);
    assign o_read_data     = r_rdata;
    assign o_status        = r_status;
    assign o_byte_count    = r_count;
    assign o_alloc_address = r_alloc;

    // checks
    `BPGM_ASSERT(a_fail_no_count, i_clk, i_rst_n, o_done && o_status != ST_OK |-> o_byte_count == 4'd0 && o_read_data == 64'd0)
    `BPGM_ASSERT(a_accept_busy, i_clk, i_rst_n, start && !busy |=> busy && !o_done)
    `BPGM_ASSERT(a_rv_scan, i_clk, i_rst_n, r_rv |-> r_state == S_SCAN || r_state == S_SCAN_END)
    `BPGM_NEVER(a_alloc_only, i_clk, i_rst_n, o_done && o_alloc_address != 32'd0 && r_op != OP_ALLOC)
endmodule

### verif/tb.sv
// Self-checking testbench for the byte-granular permission guest memory unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpgm_pkg::*;

    localparam int  MEM_SIZE   = 65536;
    localparam int  ACCESS_MAX = 8;
    localparam int  STALL_LIMIT = 300000;

    typedef struct packed {
        logic [63:0] read_data;
        t_status     status;
        logic [3:0]  byte_count;
        logic [31:0] alloc_address;
    } t_mem_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [31:0] i_address;
    logic [16:0] i_length;
    logic [63:0] i_write_data;
    logic [3:0]  i_perm_bits;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        o_done;
    logic [63:0] o_read_data;
    logic [2:0]  o_status;
    logic [3:0]  o_byte_count;
    logic [31:0] o_alloc_address;

    byte_permission_guest_memory_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_address(i_address), .i_length(i_length),
        .i_write_data(i_write_data), .i_perm_bits(i_perm_bits),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_done(o_done),
        .o_read_data(o_read_data), .o_status(o_status),
        .o_byte_count(o_byte_count), .o_alloc_address(o_alloc_address)
    );

    // Shadow copy of guest memory, permissions and allocator
    logic [7:0]  shadow_bytes[MEM_SIZE];
    logic [3:0]  shadow_perms[MEM_SIZE];
    logic [31:0] shadow_base;
    logic [31:0] shadow_next_free;

    t_mem_result pending_results[$];
    int          mismatch_count;
    int          request_count;
    int          result_count;
    int          idle_cycles;
    bit          steady_send;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [33:0] window_end();
        logic [33:0] t;
        t = {2'b0, shadow_base} + 34'h1_0000;
        if (t > 34'h1_0000_0000) t = 34'h1_0000_0000;
        return t;
    endfunction

    function automatic void fill_perm_range(logic [33:0] off, int unsigned len,
                                            logic [3:0] pb);
        for (int unsigned i = 0; i < len; i++)
            shadow_perms[16'(off + i)] = pb;
    endfunction

    // Compute the expected result of one request and update the shadow state
    function automatic t_mem_result apply_request(t_op op, logic [31:0] addr,
            logic [16:0] len, logic [63:0] wd, logic [3:0] pb);
        t_mem_result r;
        logic [33:0] top;
        logic [33:0] off;
        logic [33:0] aligned;
        logic [15:0] k;
        logic [3:0]  p;
        bit          in_win;
        bit          granted;
        r = '0;
        r.status = ST_OK;
        top = window_end();
        in_win = ({2'b0, addr} >= {2'b0, shadow_base}) &&
                 ({2'b0, addr} + {17'b0, len} <= top);
        off = {2'b0, addr} - {2'b0, shadow_base};
        case (op)
            OP_READ, OP_WRITE: begin
                if (len == 0 || len > ACCESS_MAX) begin
                    r.status = ST_BAD_LENGTH;
                end else if (!in_win) begin
                    r.status = (op == OP_WRITE) ? ST_WRITE_FAULT : ST_READ_FAULT;
                end else begin
                    granted = 1'b1;
                    for (int i = 0; i < len; i++) begin
                        p = shadow_perms[16'(off + i)];
                        if (op == OP_WRITE ? (p & (PERM_WRITE | PERM_RAW)) == 0
                                           : (p & PERM_READ) == 0)
                            granted = 1'b0;
                    end
                    if (!granted) begin
                        r.status = ST_DENIED;
                    end else begin
                        for (int i = 0; i < len; i++) begin
                            k = 16'(off + i);
                            if (op == OP_READ) begin
                                r.read_data[8*i +: 8] = shadow_bytes[k];
                            end else begin
                                shadow_bytes[k] = wd[8*i +: 8];
                                if (shadow_perms[k] & PERM_RAW)
                                    shadow_perms[k] = PERM_READ | PERM_WRITE |
                                                      (shadow_perms[k] & PERM_EXEC);
                            end
                        end
                        r.byte_count = len[3:0];
                    end
                end
            end
            OP_PERM: begin
                if (!in_win) r.status = ST_WRITE_FAULT;
                else fill_perm_range(off, len, pb);
            end
            default: begin
                aligned = ({17'b0, len} + ALLOC_ROUND) & ALLOC_MASK;
                if (shadow_next_free < shadow_base ||
                    {2'b0, shadow_next_free} + aligned >= top) begin
                    r.status = ST_OOM;
                end else begin
                    fill_perm_range({2'b0, shadow_next_free - shadow_base}, len, pb);
                    r.alloc_address = shadow_next_free;
                    shadow_next_free = 32'({2'b0, shadow_next_free} + aligned);
                end
            end
        endcase
        return r;
    endfunction

    // Send one request; record its expected result at the accepting edge
    task automatic send_request(t_op op, logic [31:0] addr, logic [16:0] len,
                                logic [63:0] wd, logic [3:0] pb);
        if (!steady_send && $urandom_range(0, 99) < 32)
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        @(negedge i_clk);
        i_operation  = op;
        i_address    = addr;
        i_length     = len;
        i_write_data = wd;
        i_perm_bits  = pb;
        start        = 1'b1;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_request(op, addr, len, wd, pb));
        request_count++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Base register write, only with the unit idle
    task automatic write_base(logic [31:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        shadow_base      = value;
        shadow_next_free = value;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_mem_result want;
        if (i_rst_n && o_done) begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("ERROR: result with no request pending, status %0d", o_status);
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data || o_status !== want.status ||
                    o_byte_count !== want.byte_count ||
                    o_alloc_address !== want.alloc_address) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("ERROR: exp data %h st %0d cnt %0d alloc %h, got %h %0d %0d %h",
                                 want.read_data, want.status, want.byte_count,
                                 want.alloc_address, o_read_data, o_status,
                                 o_byte_count, o_alloc_address);
                end
            end
        end
    end

    // Watchdog on cycles without progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("** byte_permission_guest_memory_unit: FAILED **");
            $finish;
        end
    end

    task automatic test_reset_perms();
        send_request(OP_READ, 32'h0, 17'd8, 64'h0, 4'h0);         // no read bit yet
        send_request(OP_WRITE, 32'h0, 17'd8, 64'hFFEE_DDCC_BBAA_9988, 4'h0);
        send_request(OP_READ, 32'h0, 17'd8, 64'h0, 4'h0);
        send_request(OP_READ, 32'h3, 17'd1, 64'h0, 4'h0);
    endtask

    task automatic test_lengths();
        send_request(OP_READ, 32'h10, 17'd0, 64'h0, 4'h0);
        send_request(OP_WRITE, 32'h10, 17'd9, 64'h0, 4'h0);
        send_request(OP_READ, 32'h10, 17'h1_FFFF, 64'h0, 4'h0);
    endtask

    task automatic test_window_edges();
        send_request(OP_READ, 32'hFFFF, 17'd2, 64'h0, 4'h0);
        send_request(OP_WRITE, 32'h1_0000, 17'd1, 64'h0, 4'h0);
        send_request(OP_WRITE, 32'hFFFF_FFFF, 17'd8, 64'h0, 4'h0);
        send_request(OP_PERM, 32'hFFF0, 17'd17, 64'h0, 4'hF);
        send_request(OP_PERM, 32'hFFFF_FFFF, 17'd0, 64'h0, 4'hF);
        send_request(OP_WRITE, 32'hFFF8, 17'd8, 64'h0123_4567_89AB_CDEF, 4'h0);
    endtask

    task automatic test_perm_changes();
        send_request(OP_PERM, 32'h100, 17'd8, 64'h0, PERM_EXEC | PERM_RAW);
        send_request(OP_WRITE, 32'h100, 17'd8, 64'h5555_AAAA_5555_AAAA, 4'h0);
        send_request(OP_READ, 32'h100, 17'd8, 64'h0, 4'h0);
        send_request(OP_PERM, 32'h104, 17'd1, 64'h0, 4'h0);
        send_request(OP_WRITE, 32'h100, 17'd8, 64'h0, 4'h0);
        send_request(OP_PERM, 32'h0, 17'h1_0000, 64'h0, PERM_READ);  // whole window
        send_request(OP_WRITE, 32'h200, 17'd4, 64'h0, 4'h0);
    endtask

    task automatic test_allocation();
        send_request(OP_ALLOC, 32'h0, 17'd0, 64'h0, 4'h3);
        send_request(OP_ALLOC, 32'h0, 17'd1, 64'h0, 4'h3);
        send_request(OP_ALLOC, 32'h0, 17'd17, 64'h0, 4'hB);
        send_request(OP_ALLOC, 32'h0, 17'h1_0000, 64'h0, 4'h3);      // out of memory
        send_request(OP_WRITE, 32'h10, 17'd8, 64'h1122_3344_5566_7788, 4'h0);
    endtask

    task automatic test_base_moves();
        write_base(32'hFFFF_8000);                                   // top capped
        send_request(OP_WRITE, 32'hFFFF_FFF8, 17'd8, 64'hDEAD_BEEF_CAFE_F00D, 4'h0);
        send_request(OP_READ, 32'hFFFF_FFF8, 17'd8, 64'h0, 4'h0);
        send_request(OP_READ, 32'h0000_0000, 17'd1, 64'h0, 4'h0);
        send_request(OP_ALLOC, 32'h0, 17'h7FF0, 64'h0, 4'h1);
        write_base(32'hFFFF_FFFF);                                   // one byte window
        send_request(OP_ALLOC, 32'h0, 17'd0, 64'h0, 4'h1);
        send_request(OP_ALLOC, 32'h0, 17'd1, 64'h0, 4'h1);
        send_request(OP_READ, 32'hFFFF_FFFF, 17'd1, 64'h0, 4'h0);
    endtask

    task automatic test_random_traffic();
        t_op         op;
        logic [31:0] addr;
        logic [16:0] len;
        int          pick;
        for (int n = 0; n < 400; n++) begin
            steady_send = (n >= 150 && n < 230);
            if (n == 100) wait_drained();
            if (n % 100 == 50)
                write_base($urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 255)) << 8);
            op = t_op'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 5) addr = $urandom;
            else addr = shadow_base + 32'($urandom_range(0, MEM_SIZE + 16) % 1024)
                        + (pick < 20 ? 32'(MEM_SIZE - 1024) : 32'h0);
            if (op == OP_READ || op == OP_WRITE)
                len = ($urandom_range(0, 19) == 0) ? 17'($urandom) : 17'($urandom_range(1, 8));
            else if ($urandom_range(0, 199) == 0)
                len = 17'h1_0000;
            else
                len = 17'($urandom_range(0, 48));
            send_request(op, addr, len, {$urandom, $urandom}, 4'($urandom));
        end
        steady_send = 1'b0;
    endtask

    initial begin
        start = 1'b0; i_operation = OP_READ; i_address = '0; i_length = '0;
        i_write_data = '0; i_perm_bits = '0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        mismatch_count = 0; request_count = 0; result_count = 0; idle_cycles = 0;
        steady_send = 1'b0;
        for (int i = 0; i < MEM_SIZE; i++) begin
            shadow_bytes[i] = 8'h0;
            shadow_perms[i] = PERM_RESET;
        end
        shadow_base = '0;
        shadow_next_free = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_perms();
        test_lengths();
        test_window_edges();
        test_perm_changes();
        test_allocation();
        test_base_moves();
        write_base(32'h0);
        test_random_traffic();

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d requests and %0d results: reads, writes, permission fills,",
                 request_count, result_count);
        $display("allocations, window edges, bad lengths and several base settings.");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** byte_permission_guest_memory_unit: PASSED **");
        else
            $display("** byte_permission_guest_memory_unit: FAILED **");
        $finish;
    end
endmodule
